// File: src/mreb_pkg.sv
`timescale 1ns / 1ps

package mreb_pkg;

    localparam int CHANNELS   = 4;
    localparam int ROWS       = 4;
    localparam int VAL_W      = 11;
    localparam int STEP_W     = 8;
    localparam int ENC_W      = 7;
    localparam int ROW_W      = 2;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [3:0]       KIND_NOTE_ON = 4'd9;
    localparam logic [3:0]       KIND_CC      = 4'd11;
    localparam logic [ENC_W-1:0] NOTE_LOCK    = 7'd9;
    localparam logic [ENC_W-1:0] NOTE_FINE    = 7'd10;
    localparam logic [ENC_W-1:0] CC_FIRST     = 7'd71;
    localparam logic [ENC_W-1:0] CC_LAST      = 7'd78;
    localparam logic [VAL_W-1:0] VALUE_MAX    = 11'd2000;

    // register map: coarse steps at indexes 0..3, fine steps at 4..7
    localparam logic [2:0] REG_FINE_FIRST = 3'd4;

    typedef logic [ROWS-1:0][STEP_W-1:0] step_bank_t;

    typedef struct packed {
        logic [3:0]       msg_kind;
        logic [ENC_W-1:0] data_one;
        logic [ENC_W-1:0] data_two;
    } item_t;

    typedef struct packed {
        logic [ROW_W-1:0]                   row;
        logic [CHANNELS-1:0]                written_mask;
        logic [CHANNELS-1:0][VAL_W-1:0]     value;
        logic [CHANNELS-1:0]                active_mask;
        logic                               lock_state;
        logic                               fine_state;
        logic [CHANNELS-1:0]                red_mask;
        logic [CHANNELS-1:0]                blue_mask;
    } result_t;

    function automatic logic [VAL_W-1:0] row_reset_value(input logic [ROW_W-1:0] r);
        logic [VAL_W-1:0] v;
        unique case (r)
            2'd0:    v = 11'd1000;
            2'd1:    v = 11'd1000;
            2'd2:    v = 11'd400;
            default: v = 11'd800;
        endcase
        return v;
    endfunction

    function automatic logic [STEP_W-1:0] coarse_reset_value(input logic [ROW_W-1:0] r);
        logic [STEP_W-1:0] v;
        unique case (r)
            2'd0:    v = 8'd20;
            2'd1:    v = 8'd20;
            default: v = 8'd10;
        endcase
        return v;
    endfunction

    function automatic logic [STEP_W-1:0] fine_reset_value(input logic [ROW_W-1:0] r);
        logic [STEP_W-1:0] v;
        unique case (r)
            2'd0:    v = 8'd2;
            2'd1:    v = 8'd2;
            default: v = 8'd1;
        endcase
        return v;
    endfunction

endpackage

// File: src/mreb_lane.sv
`timescale 1ns / 1ps

module mreb_lane
    import mreb_pkg::*;
(
    input  logic [VAL_W-1:0]  cur,
    input  logic [ENC_W-1:0]  enc,
    input  logic [STEP_W-1:0] step,
    output logic [VAL_W-1:0]  nv
);

    localparam int PROD_W = ENC_W + STEP_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [ENC_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] cur_ext;

    // values 64..127 count down by 128 - value; 64 gives a magnitude of 64
    assign mag     = enc[ENC_W-1] ? (ENC_W'(0) - enc) : enc;
    assign prod    = PROD_W'(mag) * PROD_W'(step);
    assign cur_ext = PROD_W'(cur);
    assign sum     = SUM_W'(cur) + SUM_W'(prod);

    always_comb begin
        if (!enc[ENC_W-1]) begin
            if (sum > SUM_W'(VALUE_MAX)) begin
                nv = VALUE_MAX;
            end else begin
                nv = sum[VAL_W-1:0];
            end
        end else begin
            if (prod >= cur_ext) begin
                nv = '0;
            end else begin
                nv = cur - prod[VAL_W-1:0];
            end
        end
    end

endmodule

// File: src/mreb_core.sv
`timescale 1ns / 1ps

module mreb_core
    import mreb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  item_t      item,
    input  step_bank_t coarse_step,
    input  step_bank_t fine_step,
    output result_t    result
);

    logic [CHANNELS-1:0][ROWS-1:0][VAL_W-1:0] knob_reg;
    logic [CHANNELS-1:0] selected_reg, selected_next;
    logic [CHANNELS-1:0] red_reg, red_next;
    logic [CHANNELS-1:0] blue_reg, blue_next;
    logic                locked_reg, locked_next;
    logic                fine_reg, fine_next;

    logic [ROW_W-1:0]            row;
    logic [CHANNELS-1:0]         wr_en;
    logic [STEP_W-1:0]           step;
    logic [2:0]                  cc_idx;
    logic [CHANNELS-1:0][VAL_W-1:0] old_val;
    logic [CHANNELS-1:0][VAL_W-1:0] new_val;
    logic [CHANNELS-1:0]         written;
    logic                        is_cc;

    assign is_cc  = (item.msg_kind == KIND_CC) && (item.data_one >= CC_FIRST)
                    && (item.data_one <= CC_LAST);
    assign cc_idx = 3'(item.data_one - CC_FIRST);

    always_comb begin
        row   = '0;
        wr_en = '0;
        if (is_cc) begin
            if (!cc_idx[2]) begin
                // base encoder: one channel, selected or not
                wr_en = CHANNELS'(1) << cc_idx[1:0];
            end else begin
                row   = cc_idx[1:0];
                wr_en = selected_reg;
            end
        end
    end

    assign step = fine_reg ? fine_step[row] : coarse_step[row];

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_lane
            assign old_val[c] = knob_reg[c][row];
            mreb_lane u_lane (
                .cur  (old_val[c]),
                .enc  (item.data_two),
                .step (step),
                .nv   (new_val[c])
            );
            assign written[c] = wr_en[c] && (new_val[c] != old_val[c]);
        end
    endgenerate

    always_comb begin
        selected_next = selected_reg;
        red_next      = red_reg;
        blue_next     = blue_reg;
        locked_next   = locked_reg;
        fine_next     = fine_reg;
        if (item.msg_kind == KIND_NOTE_ON) begin
            priority if (!locked_reg && item.data_one < ENC_W'(CHANNELS)) begin
                selected_next[item.data_one[ROW_W-1:0]] = (item.data_two != '0);
                red_next[item.data_one[ROW_W-1:0]]      = (item.data_two != '0);
            end else if (item.data_one == NOTE_LOCK && item.data_two != '0) begin
                if (selected_reg != '0) begin
                    locked_next = !locked_reg;
                    blue_next   = locked_next ? (blue_reg | selected_reg)
                                              : (blue_reg & ~selected_reg);
                    red_next    = red_reg & ~selected_reg;
                    if (!locked_next) begin
                        selected_next = '0;
                    end
                end
            end else if (item.data_one == NOTE_FINE) begin
                fine_next = (item.data_two != '0);
            end else begin
                fine_next = fine_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                for (int r = 0; r < ROWS; r++) begin
                    knob_reg[ch][r] <= row_reset_value(ROW_W'(r));
                end
            end
            selected_reg <= '0;
            red_reg      <= '0;
            blue_reg     <= '0;
            locked_reg   <= 1'b0;
            fine_reg     <= 1'b0;
        end else if (fire) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (wr_en[ch]) begin
                    knob_reg[ch][row] <= new_val[ch];
                end
            end
            selected_reg <= selected_next;
            red_reg      <= red_next;
            blue_reg     <= blue_next;
            locked_reg   <= locked_next;
            fine_reg     <= fine_next;
        end
    end

    always_comb begin
        result.row          = row;
        result.written_mask = written;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            result.value[ch] = wr_en[ch] ? new_val[ch] : old_val[ch];
        end
        result.active_mask  = selected_next;
        result.lock_state   = locked_next;
        result.fine_state   = fine_next;
        result.red_mask     = red_next;
        result.blue_mask    = blue_next;
    end

endmodule

// File: src/midi_relative_encoder_param_bank.sv
`timescale 1ns / 1ps
// MIDI relative-encoder parameter bank: 4 channels x 4 rows of knob values.
// Input channel (s_*): one MIDI message per transaction (status nibble and
// two data bytes). Result channel (m_*): exactly one result per message,
// reporting one row of the bank plus selection, lock, fine mode and the
// indicator masks, all as they stand after the message.
// An accepted message passes through the input register, then the result
// register, before m_valid rises and the result can be taken.
// Throughput: one message per cycle while m_ready stays high; the update is a
// single pass through four parallel multiply/saturate lanes.
// When the receiver stalls, the result stays in its register and one more
// message can sit in the input register; s_ready drops only once both are
// full. The APB port holds the eight step registers (coarse at 0x00..0x0C,
// fine at 0x10..0x1C) and should be written while no transaction is in flight.
// Reset (aresetn low, synchronous) restores the bank to 1000/1000/400/800
// per row, clears selection, lock, fine mode and indicators, restores the
// step registers and empties both pipeline registers.
module midi_relative_encoder_param_bank
    import mreb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [3:0]            s_msg_kind,
    input  logic [ENC_W-1:0]      s_data_one,
    input  logic [ENC_W-1:0]      s_data_two,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROW_W-1:0]      m_row,
    output logic [CHANNELS-1:0]   m_written_mask,
    output logic [VAL_W-1:0]      m_value_ch0,
    output logic [VAL_W-1:0]      m_value_ch1,
    output logic [VAL_W-1:0]      m_value_ch2,
    output logic [VAL_W-1:0]      m_value_ch3,
    output logic [CHANNELS-1:0]   m_active_mask,
    output logic                  m_lock_state,
    output logic                  m_fine_state,
    output logic [CHANNELS-1:0]   m_red_mask,
    output logic [CHANNELS-1:0]   m_blue_mask,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    step_bank_t coarse_reg;
    step_bank_t fine_reg;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    result_t    core_res;
    logic       advance;
    logic [2:0] cfg_idx;
    logic       cfg_wr;

    // configuration
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                coarse_reg[r] <= coarse_reset_value(ROW_W'(r));
                fine_reg[r]   <= fine_reset_value(ROW_W'(r));
            end
        end else if (cfg_wr) begin
            if (cfg_idx < REG_FINE_FIRST) begin
                coarse_reg[cfg_idx[1:0]] <= pwdata[STEP_W-1:0];
            end else begin
                fine_reg[cfg_idx[1:0]] <= pwdata[STEP_W-1:0];
            end
        end
    end

    assign prdata = (cfg_idx < REG_FINE_FIRST) ? CFG_DATA_W'(coarse_reg[cfg_idx[1:0]])
                                               : CFG_DATA_W'(fine_reg[cfg_idx[1:0]]);

    // pipeline handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.msg_kind <= s_msg_kind;
            in_item_reg.data_one <= s_data_one;
            in_item_reg.data_two <= s_data_two;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    mreb_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (advance),
        .item        (in_item_reg),
        .coarse_step (coarse_reg),
        .fine_step   (fine_reg),
        .result      (core_res)
    );

    assign m_valid        = out_valid_reg;
    assign m_row          = out_res_reg.row;
    assign m_written_mask = out_res_reg.written_mask;
    assign m_value_ch0    = out_res_reg.value[0];
    assign m_value_ch1    = out_res_reg.value[1];
    assign m_value_ch2    = out_res_reg.value[2];
    assign m_value_ch3    = out_res_reg.value[3];
    assign m_active_mask  = out_res_reg.active_mask;
    assign m_lock_state   = out_res_reg.lock_state;
    assign m_fine_state   = out_res_reg.fine_state;
    assign m_red_mask     = out_res_reg.red_mask;
    assign m_blue_mask    = out_res_reg.blue_mask;

endmodule

// File: tb/midi_relative_encoder_param_bank_tb.sv
`timescale 1ns / 1ps

module midi_relative_encoder_param_bank_tb;
    import mreb_pkg::*;

    localparam logic [3:0]       KIND_MIN        = 4'h0;
    localparam logic [3:0]       KIND_MAX        = 4'hF;
    localparam logic [ENC_W-1:0] CC_ROW_FIRST    = ENC_W'(CC_FIRST + CHANNELS);
    localparam int               ENC_UP_MAX      = 63;
    localparam int               ENC_SPAN        = 128;
    localparam int               REG_STRIDE      = 4;
    localparam int               NUM_PHASES      = 8;
    localparam int               ITEMS_PER_PHASE = 130;
    localparam int               DRAIN_CYCLES    = 8;
    localparam int               MAX_REPORTS     = 40;
    localparam int               SIDE_SRC        = 0;
    localparam int               SIDE_SINK       = 1;

    typedef enum int {
        REG_COARSE_BASE,
        REG_COARSE_AMPLITUDE,
        REG_COARSE_FREQUENCY,
        REG_COARSE_SHAPE,
        REG_FINE_BASE,
        REG_FINE_AMPLITUDE,
        REG_FINE_FREQUENCY,
        REG_FINE_SHAPE
    } step_reg_e;

    typedef struct packed {
        item_t   msg;
        logic    known;
        result_t lit;
    } plan_row_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic [3:0]            s_msg_kind = '0;
    logic [ENC_W-1:0]      s_data_one = '0;
    logic [ENC_W-1:0]      s_data_two = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [ROW_W-1:0]      m_row;
    logic [CHANNELS-1:0]   m_written_mask;
    logic [VAL_W-1:0]      m_value_ch0;
    logic [VAL_W-1:0]      m_value_ch1;
    logic [VAL_W-1:0]      m_value_ch2;
    logic [VAL_W-1:0]      m_value_ch3;
    logic [CHANNELS-1:0]   m_active_mask;
    logic                  m_lock_state;
    logic                  m_fine_state;
    logic [CHANNELS-1:0]   m_red_mask;
    logic [CHANNELS-1:0]   m_blue_mask;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the knob bank, selection and step registers
    logic [VAL_W-1:0]    knob_bank [ROWS][CHANNELS];
    logic [CHANNELS-1:0] sel_mask;
    logic [CHANNELS-1:0] red_led;
    logic [CHANNELS-1:0] blue_led;
    logic                is_locked;
    logic                fine_on;
    logic [STEP_W-1:0]   step_coarse [ROWS];
    logic [STEP_W-1:0]   step_fine [ROWS];

    result_t   owed_reports [$];
    plan_row_t plan [$];
    int        calm_left [2];
    int        errors = 0;

    midi_relative_encoder_param_bank dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_msg_kind     (s_msg_kind),
        .s_data_one     (s_data_one),
        .s_data_two     (s_data_two),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_row          (m_row),
        .m_written_mask (m_written_mask),
        .m_value_ch0    (m_value_ch0),
        .m_value_ch1    (m_value_ch1),
        .m_value_ch2    (m_value_ch2),
        .m_value_ch3    (m_value_ch3),
        .m_active_mask  (m_active_mask),
        .m_lock_state   (m_lock_state),
        .m_fine_state   (m_fine_state),
        .m_red_mask     (m_red_mask),
        .m_blue_mask    (m_blue_mask),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // wait cycles for one transaction; runs of zero give back-to-back stretches
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm_left[side] = $urandom_range(10, 40);
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [VAL_W-1:0] turn_knob(input logic [VAL_W-1:0] cur,
                                                   input logic [ENC_W-1:0] enc,
                                                   input int r);
        int step;
        int v;
        step = fine_on ? int'(step_fine[r]) : int'(step_coarse[r]);
        v = int'(cur);
        if (int'(enc) <= ENC_UP_MAX)
            v = v + int'(enc) * step;
        else
            v = v - (ENC_SPAN - int'(enc)) * step;
        if (v < 0)
            v = 0;
        if (v > int'(VALUE_MAX))
            v = int'(VALUE_MAX);
        return VAL_W'(v);
    endfunction

    // updates the shadow state for one message and returns the row report
    function automatic result_t apply_midi(input item_t m);
        result_t             r;
        logic [CHANNELS-1:0] ch_bit;
        logic [VAL_W-1:0]    was;
        int                  k;
        r = '0;
        if (m.msg_kind == KIND_NOTE_ON) begin
            if (!is_locked && m.data_one < CHANNELS) begin
                ch_bit = '0;
                ch_bit[m.data_one[1:0]] = 1'b1;
                if (m.data_two != 0) begin
                    sel_mask = sel_mask | ch_bit;
                    red_led  = red_led | ch_bit;
                end else begin
                    sel_mask = sel_mask & ~ch_bit;
                    red_led  = red_led & ~ch_bit;
                end
            end else if (m.data_one == NOTE_LOCK && m.data_two != 0) begin
                if (sel_mask != 0) begin
                    is_locked = !is_locked;
                    if (is_locked)
                        blue_led = blue_led | sel_mask;
                    else
                        blue_led = blue_led & ~sel_mask;
                    red_led = red_led & ~sel_mask;
                    if (!is_locked)
                        sel_mask = '0;
                end
            end else if (m.data_one == NOTE_FINE) begin
                fine_on = (m.data_two != 0);
            end
        end else if (m.msg_kind == KIND_CC && m.data_one >= CC_FIRST &&
                     m.data_one <= CC_LAST) begin
            k = int'(m.data_one) - int'(CC_FIRST);
            if (k < CHANNELS) begin
                // base encoders hit their channel whether selected or not
                was = knob_bank[0][k];
                knob_bank[0][k] = turn_knob(was, m.data_two, 0);
                if (knob_bank[0][k] != was)
                    r.written_mask[k] = 1'b1;
            end else begin
                r.row = ROW_W'(k - CHANNELS);
                for (int c = 0; c < CHANNELS; c++) begin
                    if (sel_mask[c]) begin
                        was = knob_bank[r.row][c];
                        knob_bank[r.row][c] = turn_knob(was, m.data_two, int'(r.row));
                        if (knob_bank[r.row][c] != was)
                            r.written_mask[c] = 1'b1;
                    end
                end
            end
        end
        for (int c = 0; c < CHANNELS; c++)
            r.value[c] = knob_bank[r.row][c];
        r.active_mask = sel_mask;
        r.lock_state  = is_locked;
        r.fine_state  = fine_on;
        r.red_mask    = red_led;
        r.blue_mask   = blue_led;
        return r;
    endfunction

    // row 0 report with nothing selected, unlocked, coarse mode, all lights off
    function automatic result_t base_view(input logic [CHANNELS-1:0] wr,
                                          input int v0, input int v1,
                                          input int v2, input int v3);
        result_t r;
        r = '0;
        r.written_mask = wr;
        r.value[0] = VAL_W'(v0);
        r.value[1] = VAL_W'(v1);
        r.value[2] = VAL_W'(v2);
        r.value[3] = VAL_W'(v3);
        return r;
    endfunction

    task automatic plan_known(input logic [3:0] kind, input logic [ENC_W-1:0] d1,
                              input logic [ENC_W-1:0] d2, input result_t lit);
        plan_row_t e;
        e.msg   = '{msg_kind: kind, data_one: d1, data_two: d2};
        e.known = 1'b1;
        e.lit   = lit;
        plan.push_back(e);
    endtask

    task automatic plan_row(input logic [3:0] kind, input logic [ENC_W-1:0] d1,
                            input logic [ENC_W-1:0] d2);
        plan_row_t e;
        e.msg   = '{msg_kind: kind, data_one: d1, data_two: d2};
        e.known = 1'b0;
        e.lit   = '0;
        plan.push_back(e);
    endtask

    function automatic item_t draw_msg();
        item_t m;
        int    pick;
        int    k;
        pick  = $urandom_range(0, 99);
        k     = $urandom_range(0, 9);
        // encoder counts: mostly small turns either way, some edges, some anything
        if (k < 3) begin
            m.data_two = ENC_W'($urandom_range(1, 8));
        end else if (k < 6) begin
            m.data_two = ENC_W'($urandom_range(120, 127));
        end else if (k == 6) begin
            case ($urandom_range(0, 3))
                0:       m.data_two = 7'd0;
                1:       m.data_two = 7'd63;
                2:       m.data_two = 7'd64;
                default: m.data_two = 7'd127;
            endcase
        end else begin
            m.data_two = ENC_W'($urandom());
        end
        if (pick < 40) begin
            m.msg_kind = KIND_CC;
            m.data_one = CC_FIRST + ENC_W'($urandom_range(0, 7));
        end else if (pick < 62) begin
            m.msg_kind = KIND_NOTE_ON;
            m.data_one = ENC_W'($urandom_range(0, CHANNELS - 1));
            if ($urandom_range(0, 2) == 0)
                m.data_two = '0;
        end else if (pick < 70) begin
            m.msg_kind = KIND_NOTE_ON;
            m.data_one = NOTE_LOCK;
        end else if (pick < 78) begin
            m.msg_kind = KIND_NOTE_ON;
            m.data_one = NOTE_FINE;
            if ($urandom_range(0, 1) == 0)
                m.data_two = '0;
        end else begin
            m.msg_kind = 4'($urandom());
            m.data_one = ENC_W'($urandom());
            m.data_two = ENC_W'($urandom());
        end
        return m;
    endfunction

    task automatic send_msg(input item_t m, input logic known, input result_t lit);
        int      gap;
        result_t pred;
        gap = draw_wait(SIDE_SRC);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_msg_kind <= m.msg_kind;
        s_data_one <= m.data_one;
        s_data_two <= m.data_two;
        do @(posedge aclk); while (!s_ready);
        pred = apply_midi(m);
        owed_reports.push_back(known ? lit : pred);
    endtask

    task automatic wait_drained();
        while (owed_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    initial begin
        int c;
        forever begin
            c = draw_wait(SIDE_SINK);
            if (c > 0) begin
                m_ready <= 1'b0;
                repeat (c) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.row          = m_row;
            seen.written_mask = m_written_mask;
            seen.value[0]     = m_value_ch0;
            seen.value[1]     = m_value_ch1;
            seen.value[2]     = m_value_ch2;
            seen.value[3]     = m_value_ch3;
            seen.active_mask  = m_active_mask;
            seen.lock_state   = m_lock_state;
            seen.fine_state   = m_fine_state;
            seen.red_mask     = m_red_mask;
            seen.blue_mask    = m_blue_mask;
            if (owed_reports.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, row %0d", $time, m_row);
            end else begin
                want = owed_reports.pop_front();
                check_field("row", want.row, seen.row);
                check_field("written_mask", want.written_mask, seen.written_mask);
                for (int c = 0; c < CHANNELS; c++)
                    check_field($sformatf("value_ch%0d", c), want.value[c], seen.value[c]);
                check_field("active_mask", want.active_mask, seen.active_mask);
                check_field("lock_state", want.lock_state, seen.lock_state);
                check_field("fine_state", want.fine_state, seen.fine_state);
                check_field("red_mask", want.red_mask, seen.red_mask);
                check_field("blue_mask", want.blue_mask, seen.blue_mask);
            end
        end
    end

    initial begin
        item_t             m;
        logic [STEP_W-1:0] v;

        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < CHANNELS; c++)
                knob_bank[r][c] = (r == 2) ? 11'd400 : (r == 3) ? 11'd800 : 11'd1000;
            step_coarse[r] = (r < 2) ? 8'd20 : 8'd10;
            step_fine[r]   = (r < 2) ? 8'd2 : 8'd1;
        end
        sel_mask  = '0;
        red_led   = '0;
        blue_led  = '0;
        is_locked = 1'b0;
        fine_on   = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // ignored kinds and controllers just outside the encoder range
        plan_known(KIND_MIN, 127, 127, base_view(4'b0000, 1000, 1000, 1000, 1000));
        plan_known(KIND_MAX, 0, 0, base_view(4'b0000, 1000, 1000, 1000, 1000));
        plan_known(KIND_CC, ENC_W'(CC_FIRST - 1), 1,
                   base_view(4'b0000, 1000, 1000, 1000, 1000));
        plan_known(KIND_CC, ENC_W'(CC_LAST + 1), 1,
                   base_view(4'b0000, 1000, 1000, 1000, 1000));
        // base encoders: saturate high, saturate low, zero count, one step down
        plan_known(KIND_CC, CC_FIRST, 63, base_view(4'b0001, 2000, 1000, 1000, 1000));
        plan_known(KIND_CC, ENC_W'(CC_FIRST + 3), 64,
                   base_view(4'b1000, 2000, 1000, 1000, 0));
        plan_known(KIND_CC, ENC_W'(CC_FIRST + 1), 0,
                   base_view(4'b0000, 2000, 1000, 1000, 0));
        plan_known(KIND_CC, ENC_W'(CC_FIRST + 2), 127,
                   base_view(4'b0100, 2000, 1000, 980, 0));
        // row encoder with nothing selected
        plan_known(KIND_CC, CC_ROW_FIRST, 5, base_view(4'b0000, 2000, 1000, 980, 0));
        plan_row(KIND_NOTE_ON, 0, 127);
        plan_row(KIND_NOTE_ON, 2, 1);
        plan_row(KIND_NOTE_ON, 3, 0);
        plan_row(KIND_CC, ENC_W'(CC_ROW_FIRST + 1), 1);
        plan_row(KIND_CC, CC_LAST, 65);
        plan_row(KIND_NOTE_ON, NOTE_FINE, 1);
        plan_row(KIND_CC, ENC_W'(CC_ROW_FIRST + 2), 127);
        plan_row(KIND_NOTE_ON, NOTE_LOCK, 0);
        plan_row(KIND_NOTE_ON, NOTE_LOCK, 127);
        plan_row(KIND_NOTE_ON, 1, 1);
        plan_row(KIND_NOTE_ON, NOTE_FINE, 0);
        plan_row(KIND_CC, CC_ROW_FIRST, 63);
        plan_row(KIND_NOTE_ON, NOTE_LOCK, 5);
        plan_row(KIND_NOTE_ON, NOTE_LOCK, 1);
        plan_row(KIND_NOTE_ON, 127, 127);
        plan_row(KIND_CC, ENC_W'(CC_FIRST + 1), 126);

        foreach (plan[i])
            send_msg(plan[i].msg, plan[i].known, plan[i].lit);

        // phase 0 keeps the reset steps; later phases rewrite all eight registers
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                for (int i = REG_COARSE_BASE; i <= REG_FINE_SHAPE; i++) begin
                    case (ph)
                        1:       v = '1;
                        2:       v = '0;
                        3:       v = 8'd1;
                        5:       v = STEP_W'($urandom_range(0, 255));
                        default: v = STEP_W'($urandom_range(0, 24));
                    endcase
                    psel    <= 1'b1;
                    penable <= 1'b0;
                    pwrite  <= 1'b1;
                    paddr   <= CFG_ADDR_W'(i * REG_STRIDE);
                    pwdata  <= ($urandom() << STEP_W) | CFG_DATA_W'(v);
                    @(posedge aclk);
                    penable <= 1'b1;
                    @(posedge aclk);
                    if (i >= REG_FINE_BASE)
                        step_fine[i - REG_FINE_BASE] = v;
                    else
                        step_coarse[i] = v;
                end
                psel    <= 1'b0;
                penable <= 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                m = draw_msg();
                send_msg(m, 1'b0, '0);
            end
            s_valid <= 1'b0;
        end

        wait_drained();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: midi_relative_encoder_param_bank.f
src/mreb_pkg.sv
src/mreb_lane.sv
src/mreb_core.sv
src/midi_relative_encoder_param_bank.sv
tb/midi_relative_encoder_param_bank_tb.sv
